// ===== rtl/ecg_r_peak_detector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ECG R-peak detector assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ECG_R_PEAK_DETECTOR_UNIT_MACROS_SVH
`define ECG_R_PEAK_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk and switched off during reset.
`define ECG_RPD_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and switched off during reset.
`define ECG_RPD_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/ecg_rpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG R-peak detector package
// Widths, fixed-point gains, state types and control structs.
// ----------------------------------------------------------------------------
package ecg_rpd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int POS_W       = 32;
    localparam int RR_W        = 12;
    localparam int LIM_W       = 13;
    localparam int MISS_W      = 4;
    localparam int HIST_DEPTH  = 10;
    localparam int HIST_AW     = 4;
    localparam int RR_DEPTH    = 8;
    localparam int RR_AW       = 3;
    localparam int GAIN_W      = 17;
    localparam int Q_SHIFT     = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;

    localparam logic [RR_W-1:0]   RR_MAX    = 12'hFFF;
    localparam logic [GAIN_W-1:0] GAIN_LOW  = 17'd60293;
    localparam logic [GAIN_W-1:0] GAIN_HIGH = 17'd76022;
    localparam logic [GAIN_W-1:0] GAIN_MISS = 17'd108790;

    localparam logic [CFG_IDX_W-1:0] CFG_SIG_THR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SB_THR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RR_INIT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIM = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EVAL, ST_CLASS, ST_SB_RD, ST_SB_CHK, ST_RR_WAIT, ST_THR, ST_FIN
    } det_state_t;

    typedef enum logic [2:0] {
        RU_IDLE, RU_WR_OK, RU_WR_REC, RU_SUM, RU_LIM
    } rr_state_t;

    typedef struct packed {
        logic            fill;
        logic [RR_W-1:0] init_rr;
        logic            push;
        logic            push_ok;
        logic [RR_W-1:0] rr;
    } rr_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LIM_W-1:0] low;
        logic [LIM_W-1:0] high;
        logic [LIM_W-1:0] miss;
    } rr_stat_t;

endpackage

// ===== rtl/ecg_rpd_rr_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG R-peak detector RR history unit
// Holds both RR histories in one memory, averages one of them and derives
// the RR window and miss limits with a shared multiplier.
// ----------------------------------------------------------------------------
module ecg_rpd_rr_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ecg_rpd_pkg::rr_ctrl_t ctrl,
    output ecg_rpd_pkg::rr_stat_t stat
);
    import ecg_rpd_pkg::*;

    localparam int PROD_W = RR_W + GAIN_W;

    rr_state_t state_reg, state_next;

    logic [RR_W-1:0]   mem [2*RR_DEPTH];
    logic [RR_W-1:0]   rd_data_reg;
    logic              rd_vld_reg;
    logic [RR_AW-1:0]  wp_ok_reg, wp_rec_reg;
    logic [RR_DEPTH-1:0] vld_ok_reg, vld_rec_reg;
    logic              half_ok_reg;
    logic [RR_W-1:0]   data_reg;
    logic [RR_AW:0]    k_reg;
    logic [RR_W-1:0]   acc_reg, avg_reg;
    logic [1:0]        lim_idx_reg;
    logic [LIM_W-1:0]  low_reg, high_reg, miss_reg;
    logic              done_reg;

    logic              mem_we;
    logic [RR_AW:0]    mem_waddr, mem_raddr;
    logic              sel_vld;
    logic [RR_W-1:0]   term;
    logic [GAIN_W-1:0] gain;
    logic [PROD_W-1:0] prod;
    logic [LIM_W-1:0]  lim_val;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            RU_IDLE: begin
                if (ctrl.push) begin
                    state_next = ctrl.push_ok ? RU_WR_OK : RU_WR_REC;
                end
            end
            RU_WR_OK:  state_next = RU_WR_REC;
            RU_WR_REC: state_next = RU_SUM;
            RU_SUM: begin
                if (k_reg == (RR_AW+1)'(RR_DEPTH)) begin
                    state_next = RU_LIM;
                end
            end
            RU_LIM: begin
                if (lim_idx_reg == 2'd2) begin
                    state_next = RU_IDLE;
                end
            end
            default: state_next = RU_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = (state_reg == RU_WR_OK) || (state_reg == RU_WR_REC);
        mem_waddr = (state_reg == RU_WR_OK) ? {1'b1, wp_ok_reg} : {1'b0, wp_rec_reg};
        mem_raddr = {half_ok_reg, k_reg[RR_AW-1:0]};
        sel_vld   = half_ok_reg ? vld_ok_reg[k_reg[RR_AW-1:0]]
                                : vld_rec_reg[k_reg[RR_AW-1:0]];
        // An entry not written since the last fill holds the initial interval.
        term      = (rd_vld_reg ? rd_data_reg : ctrl.init_rr) >> 3;
        case (lim_idx_reg)
            2'd0:    gain = GAIN_LOW;
            2'd1:    gain = GAIN_HIGH;
            default: gain = GAIN_MISS;
        endcase
        prod    = PROD_W'(avg_reg) * PROD_W'(gain);
        lim_val = prod[Q_SHIFT +: LIM_W];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= data_reg;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= RU_IDLE;
            wp_ok_reg   <= '0;
            wp_rec_reg  <= '0;
            vld_ok_reg  <= '0;
            vld_rec_reg <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            miss_reg    <= '0;
            done_reg    <= 1'b0;
            k_reg       <= '0;
            lim_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RU_LIM) && (lim_idx_reg == 2'd2);
            case (state_reg)
                RU_WR_OK: begin
                    vld_ok_reg[wp_ok_reg] <= 1'b1;
                    wp_ok_reg             <= wp_ok_reg + 1'b1;
                end
                RU_WR_REC: begin
                    vld_rec_reg[wp_rec_reg] <= 1'b1;
                    wp_rec_reg              <= wp_rec_reg + 1'b1;
                    k_reg                   <= '0;
                end
                RU_SUM: begin
                    k_reg       <= k_reg + 1'b1;
                    lim_idx_reg <= '0;
                end
                RU_LIM: begin
                    case (lim_idx_reg)
                        2'd0:    low_reg  <= lim_val;
                        2'd1:    high_reg <= lim_val;
                        default: miss_reg <= lim_val;
                    endcase
                    lim_idx_reg <= lim_idx_reg + 1'b1;
                end
                default: ;
            endcase
            if (ctrl.fill) begin
                vld_ok_reg  <= '0;
                vld_rec_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == RU_IDLE && ctrl.push) begin
            half_ok_reg <= ctrl.push_ok;
            data_reg    <= ctrl.rr;
        end
        if (state_reg == RU_WR_REC) begin
            acc_reg <= '0;
        end
        if (state_reg == RU_SUM) begin
            rd_vld_reg <= sel_vld;
            if (k_reg != '0) begin
                acc_reg <= acc_reg + term;
            end
            if (k_reg == (RR_AW+1)'(RR_DEPTH)) begin
                avg_reg <= acc_reg + term;
            end
        end
    end

    assign stat.busy = (state_reg != RU_IDLE);
    assign stat.done = done_reg;
    assign stat.low  = low_reg;
    assign stat.high = high_reg;
    assign stat.miss = miss_reg;

endmodule

// ===== rtl/ecg_r_peak_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG R-peak detector
// QRS detection on integrated ECG samples with adaptive thresholds.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_ stream, one per beat; every sample gives exactly one
// result beat on the m_ stream, carrying the R-peak flags, its value and
// position, the irregular flag and threshold one after that sample.
// Registers are written on the cfg_ channel, which is ready while idle.
// One sample at a time is processed by a sequencer: a non-peak sample goes
// straight to the final step, a noise peak through evaluation and threshold
// update, a miss without searchback through evaluation and classification,
// an accepted beat also through the RR wait and threshold update. Searchback
// reads the peak history one entry at a time, a read and a check step each;
// RR averaging reads one RR entry per cycle and forms the window and miss
// limits on a shared multiplier. The next sample is taken while a result still
// waits in the output register; if the receiver stalls, the sequencer holds in
// its final step until the register frees. Reset clears control state and loads
// register defaults; memories need no clearing pass as entries carry valid bits.
// ----------------------------------------------------------------------------
module ecg_r_peak_detector_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ecg_rpd_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] rpeak_found, [16:1] rpeak_value, [48:17] rpeak_position,
    // [49] irregular_beat, [65:50] current_threshold, [71:66] zero
    output logic [ecg_rpd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tuser,   // [0] rpeak_by_searchback
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ecg_rpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ecg_rpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ecg_rpd_pkg::*;

    det_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] prev0_reg, prev1_reg, peak_reg;
    logic [POS_W-1:0]    cnt_reg, rr_reg, last_reg, pos_reg;
    logic [SAMPLE_W-1:0] sig_reg, noise_reg, t1_reg, t2_reg, val_reg;
    logic [MISS_W-1:0]   miss_reg, miss_lim_reg;
    logic [RR_W-1:0]     init_rr_reg;
    logic                found_reg, sb_reg, irr_reg;
    logic [HIST_AW-1:0]  pw_reg, sb_i_reg;
    logic [HIST_DEPTH-1:0] hvld_reg;
    logic                sb_rdv_reg;

    logic [SAMPLE_W+POS_W-1:0] hist_mem [HIST_DEPTH];
    logic [SAMPLE_W+POS_W-1:0] hist_rd_reg;

    logic                m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    rr_ctrl_t rr_ctrl;
    rr_stat_t rr_stat;

    logic                s_acc, cfg_acc, out_free, is_peak;
    logic [HIST_AW:0]    sb_sum;
    logic [HIST_AW-1:0]  sb_addr;
    logic                rr_ok, rr_long;
    logic [RR_W-1:0]     rr_sat;
    logic [SAMPLE_W-1:0] cand;
    logic                cand_pass;
    logic [SAMPLE_W+2:0] sig_acc_sum, noise_sum;
    logic [SAMPLE_W+1:0] sig_sb_sum;
    logic [SAMPLE_W:0]   lvl_diff, lvl_mag;
    logic [SAMPLE_W-1:0] lvl_q, t1_new;

    ecg_rpd_rr_unit u_rr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rr_ctrl),
        .stat    (rr_stat)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = is_peak ? ST_EVAL : ST_FIN;
                end
            end
            ST_EVAL:  state_next = (peak_reg > t1_reg) ? ST_CLASS : ST_THR;
            ST_CLASS: begin
                if (rr_ok) begin
                    state_next = ST_RR_WAIT;
                end else if (rr_long) begin
                    state_next = ST_SB_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SB_RD: state_next = ST_SB_CHK;
            ST_SB_CHK: begin
                if (cand_pass) begin
                    state_next = ST_RR_WAIT;
                end else if (sb_i_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SB_RD;
                end
            end
            ST_RR_WAIT: begin
                if (rr_stat.done) begin
                    state_next = ST_THR;
                end
            end
            ST_THR: state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and datapath.
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        s_acc     = s_tvalid && s_tready;
        cfg_acc   = cfg_valid && cfg_ready;
        out_free  = !m_tvalid_reg || m_tready;
        is_peak   = (prev0_reg < prev1_reg) && (prev1_reg > s_tdata[SAMPLE_W-1:0]);

        // Entry i of the newest-first history sits at pw - 1 - i, modulo depth.
        sb_sum  = {1'b0, pw_reg} + (HIST_AW+1)'(HIST_DEPTH - 1) - {1'b0, sb_i_reg};
        sb_addr = (sb_sum >= (HIST_AW+1)'(HIST_DEPTH))
                  ? HIST_AW'(sb_sum - (HIST_AW+1)'(HIST_DEPTH)) : sb_sum[HIST_AW-1:0];

        rr_ok   = (rr_reg > POS_W'(rr_stat.low)) && (rr_reg < POS_W'(rr_stat.high));
        rr_long = rr_reg > POS_W'(rr_stat.miss);
        rr_sat  = (|rr_reg[POS_W-1:RR_W]) ? RR_MAX : rr_reg[RR_W-1:0];

        cand      = sb_rdv_reg ? hist_rd_reg[SAMPLE_W-1:0] : '0;
        cand_pass = cand > t2_reg;

        sig_acc_sum = (SAMPLE_W+3)'(peak_reg) + ((SAMPLE_W+3)'(sig_reg) << 3)
                      - (SAMPLE_W+3)'(sig_reg);
        noise_sum   = (SAMPLE_W+3)'(peak_reg) + ((SAMPLE_W+3)'(noise_reg) << 3)
                      - (SAMPLE_W+3)'(noise_reg);
        sig_sb_sum  = (SAMPLE_W+2)'(cand) + ((SAMPLE_W+2)'(sig_reg) << 2)
                      - (SAMPLE_W+2)'(sig_reg);

        // Quarter of the level difference, truncated toward zero.
        lvl_diff = {1'b0, sig_reg} - {1'b0, noise_reg};
        lvl_mag  = lvl_diff[SAMPLE_W] ? (~lvl_diff + 1'b1) : lvl_diff;
        lvl_q    = SAMPLE_W'(lvl_mag >> 2);
        t1_new   = lvl_diff[SAMPLE_W] ? (noise_reg - lvl_q) : (noise_reg + lvl_q);

        rr_ctrl.fill    = cfg_acc && (cfg_index == CFG_RR_INIT);
        rr_ctrl.init_rr = init_rr_reg;
        rr_ctrl.push    = ((state_reg == ST_CLASS) && rr_ok)
                          || ((state_reg == ST_SB_CHK) && cand_pass);
        rr_ctrl.push_ok = (state_reg == ST_CLASS);
        rr_ctrl.rr      = rr_sat;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EVAL) begin
            hist_mem[pw_reg] <= {cnt_reg, peak_reg};
        end
        hist_rd_reg <= hist_mem[sb_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev0_reg    <= '0;
            prev1_reg    <= '0;
            cnt_reg      <= '0;
            last_reg     <= '0;
            sig_reg      <= '0;
            noise_reg    <= '0;
            t1_reg       <= SAMPLE_W'(2000);
            t2_reg       <= SAMPLE_W'(1000);
            init_rr_reg  <= RR_W'(155);
            miss_lim_reg <= MISS_W'(5);
            miss_reg     <= '0;
            pw_reg       <= '0;
            hvld_reg     <= '0;
            sb_i_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_acc) begin
                case (cfg_index)
                    CFG_SIG_THR:  t1_reg       <= cfg_data;
                    CFG_SB_THR:   t2_reg       <= cfg_data;
                    CFG_RR_INIT:  init_rr_reg  <= cfg_data[RR_W-1:0];
                    CFG_MISS_LIM: miss_lim_reg <= cfg_data[MISS_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        prev0_reg <= prev1_reg;
                        prev1_reg <= s_tdata[SAMPLE_W-1:0];
                    end
                end
                ST_EVAL: begin
                    hvld_reg[pw_reg] <= 1'b1;
                    pw_reg <= (pw_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : pw_reg + 1'b1;
                    if (!(peak_reg > t1_reg)) begin
                        noise_reg <= noise_sum[SAMPLE_W+2:3];
                    end
                end
                ST_CLASS: begin
                    if (rr_ok) begin
                        miss_reg <= '0;
                        last_reg <= cnt_reg;
                        sig_reg  <= sig_acc_sum[SAMPLE_W+2:3];
                    end else begin
                        // At the limit the count restarts before this miss is counted.
                        miss_reg <= (miss_reg >= miss_lim_reg) ? MISS_W'(1)
                                                               : miss_reg + 1'b1;
                        sb_i_reg <= HIST_AW'(1);
                    end
                end
                ST_SB_CHK: begin
                    if (cand_pass) begin
                        last_reg <= hist_rd_reg[SAMPLE_W +: POS_W];
                        sig_reg  <= sig_sb_sum[SAMPLE_W+1:2];
                    end else begin
                        sb_i_reg <= sb_i_reg + 1'b1;
                    end
                end
                ST_THR: begin
                    t1_reg <= t1_new;
                    t2_reg <= t1_new >> 1;
                end
                ST_FIN: begin
                    if (out_free) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    peak_reg  <= prev1_reg;
                    found_reg <= 1'b0;
                    sb_reg    <= 1'b0;
                    irr_reg   <= 1'b0;
                    val_reg   <= '0;
                    pos_reg   <= '0;
                end
            end
            ST_EVAL: rr_reg <= cnt_reg - last_reg;
            ST_CLASS: begin
                if (rr_ok) begin
                    found_reg <= 1'b1;
                    val_reg   <= peak_reg;
                    pos_reg   <= cnt_reg;
                end else begin
                    irr_reg <= (miss_reg >= miss_lim_reg);
                end
            end
            ST_SB_RD: sb_rdv_reg <= hvld_reg[sb_addr];
            ST_SB_CHK: begin
                if (cand_pass) begin
                    found_reg <= 1'b1;
                    sb_reg    <= 1'b1;
                    val_reg   <= cand;
                    pos_reg   <= hist_rd_reg[SAMPLE_W +: POS_W];
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tdata_reg <= {6'b0, t1_reg, irr_reg, pos_reg, val_reg, found_reg};
                    m_tuser_reg <= sb_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/ecg_rpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG R-peak detector port checker
// Watches the top-level ports and flags results or input handshakes that break the stream rules.
// ----------------------------------------------------------------------------
`include "ecg_r_peak_detector_unit_macros.svh"

module ecg_rpd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [ecg_rpd_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ecg_rpd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                                m_tuser,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [ecg_rpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [ecg_rpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    // A stalled result beat must hold.
    `ECG_RPD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Without an accepted peak, value and position read as zero.
    `ECG_RPD_ASSERT_IMP(a_no_peak_zero, m_tvalid && !m_tdata[0], m_tdata[48:1] == 48'd0, "peak fields set without a peak")

    // A searchback result is always an accepted peak.
    `ECG_RPD_ASSERT_IMP(a_sb_found, m_tvalid && m_tuser, m_tdata[0], "searchback flag without a peak")

    // One sample at a time: the input closes straight after a beat.
    `ECG_RPD_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "input ready again straight after a beat")

endmodule

bind ecg_r_peak_detector_unit ecg_rpd_checker u_ecg_rpd_checker (.*);
